[rtl/stl_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and character classes for the source token lexer.
package stl_pkg;

    localparam int MAX_TOKEN  = 16;
    localparam int LEN_W      = $clog2(MAX_TOKEN + 1);
    localparam int ADDR_W     = $clog2(MAX_TOKEN);
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);
    localparam int NUM_KW     = 8;
    localparam int KW_MAXLEN  = 5;
    localparam int KW_IDX_W   = $clog2(KW_MAXLEN);

    localparam logic [3:0] K_IDENT    = 4'd0;
    localparam logic [3:0] K_NUMBER   = 4'd1;
    localparam logic [3:0] K_KEYWORD0 = 4'd2;
    localparam logic [3:0] K_DELIM    = 4'd10;
    localparam logic [3:0] K_ERROR    = 4'd11;

    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_EQ    = 8'h3D;

    // Keyword spellings, zero padded (zero never matches a letter).
    localparam logic [7:0] KW_TEXT [NUM_KW][KW_MAXLEN] = '{
        '{8'h69, 8'h66, 8'h00, 8'h00, 8'h00},  // if
        '{8'h65, 8'h6C, 8'h73, 8'h65, 8'h00},  // else
        '{8'h66, 8'h6F, 8'h72, 8'h00, 8'h00},  // for
        '{8'h77, 8'h68, 8'h69, 8'h6C, 8'h65},  // while
        '{8'h64, 8'h6F, 8'h00, 8'h00, 8'h00},  // do
        '{8'h69, 8'h6E, 8'h74, 8'h00, 8'h00},  // int
        '{8'h72, 8'h65, 8'h61, 8'h64, 8'h00},  // read
        '{8'h77, 8'h72, 8'h69, 8'h74, 8'h65}   // write
    };
    localparam logic [2:0] KW_LEN [NUM_KW] = '{3'd2, 3'd4, 3'd3, 3'd5, 3'd2, 3'd3, 3'd4, 3'd5};

    typedef enum logic [2:0] {
        M_IDLE,
        M_IDENT,
        M_NUMBER,
        M_DOUBLE,
        M_SLASH,
        M_COMMENT,
        M_STAR
    } scan_mode_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_READ,
        B_SEND
    } back_state_t;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_APPEND,
        OP_EMIT,
        OP_FLUSH
    } op_code_t;

    typedef struct packed {
        op_code_t   code;
        logic [3:0] kind;
        logic [7:0] ch;
        logic       last;
    } op_t;

    // One queue entry carries the work of one source byte: at most two ops.
    typedef struct packed {
        op_t op0;
        op_t op1;
    } entry_t;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_single(input logic [7:0] c);
        return c == 8'h2B || c == 8'h2D || c == 8'h2A || c == 8'h28 || c == 8'h29 ||
               c == 8'h7B || c == 8'h7D || c == 8'h3B || c == 8'h2C || c == 8'h3A;
    endfunction

    function automatic logic is_double_head(input logic [7:0] c);
        return c == 8'h3E || c == 8'h3C || c == 8'h3D || c == 8'h21;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == 8'h20 || c == 8'h09 || c == 8'h0A;
    endfunction

endpackage

[rtl/stl_front.sv]
`timescale 1ns / 1ps
// Front end: scans input bytes and turns each into up to two token ops.
module stl_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  logic [7:0]      char_code,
    input  logic            end_of_input,
    output logic            push,
    output stl_pkg::entry_t push_entry
);
    import stl_pkg::*;

    scan_mode_t mode_reg, mode_next;
    logic [7:0] held_reg, held_next;
    op_t        op0, op1;
    op_t        flush_op, st_op;
    scan_mode_t st_mode;
    logic       do_start;

    // What a byte does when scanned from idle.
    always_comb
    begin
        st_op   = '{code: OP_NONE, kind: K_DELIM, ch: char_code, last: 1'b1};
        st_mode = M_IDLE;
        if (is_space(char_code))
        begin
            st_mode = M_IDLE;
        end
        else if (is_letter(char_code))
        begin
            st_op.code = OP_APPEND;
            st_mode    = M_IDENT;
        end
        else if (is_digit(char_code))
        begin
            st_op.code = OP_APPEND;
            st_mode    = M_NUMBER;
        end
        else if (is_single(char_code))
        begin
            st_op.code = OP_EMIT;
        end
        else if (is_double_head(char_code))
        begin
            st_mode = M_DOUBLE;
        end
        else if (char_code == CH_SLASH)
        begin
            st_mode = M_SLASH;
        end
        else
        begin
            st_op.code = OP_EMIT;
            st_op.kind = K_ERROR;
        end
    end

    // Op that closes the pending token of the current mode.
    always_comb
    begin
        flush_op = '{code: OP_NONE, kind: K_DELIM, ch: held_reg, last: 1'b1};
        case (mode_reg)
            M_IDENT:
            begin
                flush_op.code = OP_FLUSH;
                flush_op.kind = K_IDENT;
            end
            M_NUMBER:
            begin
                flush_op.code = OP_FLUSH;
                flush_op.kind = K_NUMBER;
            end
            M_DOUBLE:  flush_op.code = OP_EMIT;
            M_SLASH:
            begin
                flush_op.code = OP_EMIT;
                flush_op.ch   = CH_SLASH;
            end
            default:   flush_op.code = OP_NONE;
        endcase
    end

    always_comb
    begin
        op0       = '{code: OP_NONE, kind: K_DELIM, ch: char_code, last: 1'b1};
        op1       = '{code: OP_NONE, kind: K_DELIM, ch: char_code, last: 1'b1};
        mode_next = mode_reg;
        held_next = held_reg;
        do_start  = 1'b0;
        if (end_of_input)
        begin
            op0       = flush_op;
            mode_next = M_IDLE;
            held_next = 8'h00;
        end
        else
        begin
            case (mode_reg)
                M_IDENT:
                begin
                    if (is_letter(char_code) || is_digit(char_code))
                    begin
                        op0.code = OP_APPEND;
                    end
                    else
                    begin
                        op0      = flush_op;
                        do_start = 1'b1;
                    end
                end
                M_NUMBER:
                begin
                    if (is_digit(char_code))
                    begin
                        op0.code = OP_APPEND;
                    end
                    else
                    begin
                        op0      = flush_op;
                        do_start = 1'b1;
                    end
                end
                M_DOUBLE:
                begin
                    if (char_code == CH_EQ)
                    begin
                        op0       = '{code: OP_EMIT, kind: K_DELIM, ch: held_reg, last: 1'b0};
                        op1       = '{code: OP_EMIT, kind: K_DELIM, ch: CH_EQ, last: 1'b1};
                        mode_next = M_IDLE;
                        held_next = 8'h00;
                    end
                    else
                    begin
                        op0      = flush_op;
                        do_start = 1'b1;
                    end
                end
                M_SLASH:
                begin
                    if (char_code == CH_STAR)
                    begin
                        mode_next = M_COMMENT;
                    end
                    else
                    begin
                        op0      = flush_op;
                        do_start = 1'b1;
                    end
                end
                M_COMMENT:
                begin
                    if (char_code == CH_STAR)
                    begin
                        mode_next = M_STAR;
                    end
                end
                M_STAR:
                begin
                    if (char_code == CH_SLASH)
                    begin
                        mode_next = M_IDLE;
                    end
                    else if (char_code != CH_STAR)
                    begin
                        mode_next = M_COMMENT;
                    end
                end
                default: do_start = 1'b1;
            endcase
            if (do_start)
            begin
                mode_next = st_mode;
                held_next = (st_mode == M_DOUBLE) ? char_code : 8'h00;
                if (op0.code == OP_NONE)
                begin
                    op0 = st_op;
                end
                else
                begin
                    op1 = st_op;
                end
            end
        end
    end

    assign push       = accept && (op0.code != OP_NONE);
    assign push_entry = '{op0: op0, op1: op1};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_IDLE;
            held_reg <= 8'h00;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            held_reg <= held_next;
        end
    end

endmodule

[rtl/stl_fifo.sv]
`timescale 1ns / 1ps
// Short op queue between the scanner and the token emitter.
module stl_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  stl_pkg::entry_t push_entry,
    input  logic            pop,
    output logic            full,
    output logic            not_empty,
    output stl_pkg::entry_t head
);
    import stl_pkg::*;

    entry_t              slot_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg, count_next;

    assign full      = (count_reg == QCNT_W'(QDEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

[rtl/stl_back.sv]
`timescale 1ns / 1ps
// Back end: holds the token text, resolves keywords and sends token characters.
module stl_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    input  stl_pkg::entry_t head,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [3:0]      token_kind,
    output logic [7:0]      text_char,
    output logic            last_char,
    output logic            text_truncated
);
    import stl_pkg::*;

    back_state_t        state_reg, state_next;
    logic               sel_reg, sel_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic               ovf_reg, ovf_next;
    logic [NUM_KW-1:0]  hit_reg, hit_next, hit_upd;
    logic [ADDR_W-1:0]  idx_reg, idx_next;
    logic [3:0]         kind_reg, kind_next, flush_kind;
    logic [7:0]         rd_data_reg;
    logic [7:0]         tok_mem [MAX_TOKEN];

    logic               out_valid_reg, out_valid_next;
    logic [3:0]         out_kind_reg, out_kind_next;
    logic [7:0]         out_char_reg, out_char_next;
    logic               out_last_reg, out_last_next;
    logic               out_trunc_reg, out_trunc_next;

    logic               out_free, out_load, send_last, wr_en;
    op_t                cur_op;

    assign out_free  = !out_valid_reg || out_ready;
    assign cur_op    = sel_reg ? head.op1 : head.op0;
    assign send_last = (LEN_W'(idx_reg) + LEN_W'(1)) == len_reg;

    // Running keyword match, one text position per appended character.
    always_comb
    begin
        for (int k = 0; k < NUM_KW; k++)
        begin
            hit_upd[k] = hit_reg[k] && (len_reg < LEN_W'(KW_MAXLEN)) &&
                         (KW_TEXT[k][len_reg[KW_IDX_W-1:0]] == cur_op.ch);
        end
    end

    always_comb
    begin
        flush_kind = cur_op.kind;
        if (cur_op.kind == K_IDENT && !ovf_reg)
        begin
            for (int k = 0; k < NUM_KW; k++)
            begin
                if (hit_reg[k] && len_reg == LEN_W'(KW_LEN[k]))
                begin
                    flush_kind = K_KEYWORD0 + 4'(k);
                end
            end
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (q_valid && cur_op.code == OP_FLUSH)
                begin
                    state_next = B_READ;
                end
            end
            B_READ: state_next = B_SEND;
            B_SEND:
            begin
                if (out_free)
                begin
                    state_next = send_last ? B_IDLE : B_READ;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        sel_next       = sel_reg;
        len_next       = len_reg;
        ovf_next       = ovf_reg;
        hit_next       = hit_reg;
        idx_next       = idx_reg;
        kind_next      = kind_reg;
        pop            = 1'b0;
        wr_en          = 1'b0;
        out_load       = 1'b0;
        out_kind_next  = out_kind_reg;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        out_trunc_next = out_trunc_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (q_valid && (cur_op.code != OP_EMIT || out_free))
                begin
                    case (cur_op.code)
                        OP_APPEND:
                        begin
                            if (len_reg < LEN_W'(MAX_TOKEN))
                            begin
                                wr_en    = 1'b1;
                                len_next = len_reg + LEN_W'(1);
                                hit_next = hit_upd;
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        OP_EMIT:
                        begin
                            out_load       = 1'b1;
                            out_kind_next  = cur_op.kind;
                            out_char_next  = cur_op.ch;
                            out_last_next  = cur_op.last;
                            out_trunc_next = 1'b0;
                        end
                        OP_FLUSH:
                        begin
                            kind_next = flush_kind;
                            idx_next  = '0;
                        end
                        default: ;
                    endcase
                    if (!sel_reg && head.op1.code != OP_NONE)
                    begin
                        sel_next = 1'b1;
                    end
                    else
                    begin
                        sel_next = 1'b0;
                        pop      = 1'b1;
                    end
                end
            end
            B_SEND:
            begin
                if (out_free)
                begin
                    out_load       = 1'b1;
                    out_kind_next  = kind_reg;
                    out_char_next  = rd_data_reg;
                    out_last_next  = send_last;
                    out_trunc_next = ovf_reg;
                    if (send_last)
                    begin
                        len_next = '0;
                        ovf_next = 1'b0;
                        hit_next = '1;
                    end
                    else
                    begin
                        idx_next = idx_reg + ADDR_W'(1);
                    end
                end
            end
            default: ;
        endcase
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            tok_mem[len_reg[ADDR_W-1:0]] <= cur_op.ch;
        end
        rd_data_reg <= tok_mem[idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            sel_reg       <= 1'b0;
            len_reg       <= '0;
            ovf_reg       <= 1'b0;
            hit_reg       <= '1;
            idx_reg       <= '0;
            kind_reg      <= K_IDENT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sel_reg       <= sel_next;
            len_reg       <= len_next;
            ovf_reg       <= ovf_next;
            hit_reg       <= hit_next;
            idx_reg       <= idx_next;
            kind_reg      <= kind_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_kind_reg  <= out_kind_next;
        out_char_reg  <= out_char_next;
        out_last_reg  <= out_last_next;
        out_trunc_reg <= out_trunc_next;
    end

    assign out_valid      = out_valid_reg;
    assign token_kind     = out_kind_reg;
    assign text_char      = out_char_reg;
    assign last_char      = out_last_reg;
    assign text_truncated = out_trunc_reg;

endmodule

[rtl/source_token_lexer.sv]
`timescale 1ns / 1ps
// Source token lexer: top level joining scanner, op queue and token emitter.
//
// Bytes enter at one per cycle while the four-entry op queue has room; the
// scanner turns each byte into at most two ops (append, emit a character,
// flush the buffered token). The emitter retires an append or single emit
// directly from the queue head and sends a buffered identifier or number
// one character at a time, each through a token memory read and then an
// output load; the flush op itself is handled before sending starts, and no
// further op is taken until the token is sent. Tokens keep their first 16
// characters and are flagged when longer. The output register lets a new
// character be loaded in the cycle the previous one is taken.
module source_token_lexer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  char_code,
    input  logic        end_of_input,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  token_kind,
    output logic [7:0]  text_char,
    output logic        last_char,
    output logic        text_truncated
);
    import stl_pkg::*;

    logic   q_push, q_pop, q_full, q_valid;
    entry_t q_in, q_head;

    assign in_ready = !q_full;

    stl_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (in_valid && in_ready),
        .char_code    (char_code),
        .end_of_input (end_of_input),
        .push         (q_push),
        .push_entry   (q_in)
    );

    stl_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_in),
        .pop        (q_pop),
        .full       (q_full),
        .not_empty  (q_valid),
        .head       (q_head)
    );

    stl_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_valid),
        .head           (q_head),
        .pop            (q_pop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .token_kind     (token_kind),
        .text_char      (text_char),
        .last_char      (last_char),
        .text_truncated (text_truncated)
    );

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("op queue written while full");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("op queue popped while empty");

    a_trunc_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && text_truncated) |-> (token_kind == K_IDENT || token_kind == K_NUMBER))
        else $error("truncation flag on a non ident/number token");

    a_error_single: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && token_kind == K_ERROR) |-> last_char)
        else $error("error token longer than one character");

endmodule
